// File: hw/rtl/dfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg: shared types for the framed packet deframer
// Parse phases, register indexes, ack codes, result record and the
// CRC16-CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 16;

  localparam logic [CrcW-1:0]  CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly = 16'h1021;

  // payload length each known command needs
  localparam logic [ByteW-1:0] LenMotorDrive = 8'd10;
  localparam logic [ByteW-1:0] LenShortCmd   = 8'd1;
  localparam logic [ByteW-1:0] LenPing       = 8'd0;

  // reset values of the configuration registers
  localparam logic [ByteW-1:0] RstStartFirst  = 8'hAA;
  localparam logic [ByteW-1:0] RstStartSecond = 8'h55;
  localparam logic [ByteW-1:0] RstIdDrive     = 8'd1;
  localparam logic [ByteW-1:0] RstIdEnable    = 8'd2;
  localparam logic [ByteW-1:0] RstIdEstop     = 8'd3;
  localparam logic [ByteW-1:0] RstIdPing      = 8'd4;
  localparam logic [ByteW-1:0] RstMaxLen      = 8'd255;

  typedef enum logic [2:0] {
    PH_SOF0    = 3'd0,
    PH_SOF1    = 3'd1,
    PH_MSG     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_L   = 3'd5,
    PH_CRC_H   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    CFG_START_FIRST  = 3'd0,
    CFG_START_SECOND = 3'd1,
    CFG_ID_DRIVE     = 3'd2,
    CFG_ID_ENABLE    = 3'd3,
    CFG_ID_ESTOP     = 3'd4,
    CFG_ID_PING      = 3'd5,
    CFG_MAX_LEN      = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACK_OK      = 2'd0,
    ACK_CRC_ERR = 2'd1,
    ACK_LEN_ERR = 2'd2,
    ACK_UNKNOWN = 2'd3
  } ack_code_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] start_first;
    logic [ByteW-1:0] start_second;
    logic [ByteW-1:0] id_drive;
    logic [ByteW-1:0] id_enable;
    logic [ByteW-1:0] id_estop;
    logic [ByteW-1:0] id_ping;
    logic [ByteW-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    item_kind_e       kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] msg_id;
    logic [ByteW-1:0] length;
    logic             crc_good;
    logic             accepted;
    logic             ack_wanted;
    ack_code_e        ack_code;
  } result_t;

  // MSB-first CRC16 update over one byte, unrolls to an XOR network
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ {b, {(CrcW-ByteW){1'b0}}};
    for (int k = 0; k < ByteW; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dfr_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_cfg_regs: configuration register file
// Start bytes, command ids and payload length limit, write only.
// ----------------------------------------------------------------------------
module dfr_cfg_regs (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [2:0]              cfg_index_i,
  input  wire logic [dfr_pkg::ByteW-1:0] cfg_wdata_i,
  output dfr_pkg::cfg_t                cfg_o
);

  dfr_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        dfr_pkg::CFG_START_FIRST:  cfg_d.start_first  = cfg_wdata_i;
        dfr_pkg::CFG_START_SECOND: cfg_d.start_second = cfg_wdata_i;
        dfr_pkg::CFG_ID_DRIVE:     cfg_d.id_drive     = cfg_wdata_i;
        dfr_pkg::CFG_ID_ENABLE:    cfg_d.id_enable    = cfg_wdata_i;
        dfr_pkg::CFG_ID_ESTOP:     cfg_d.id_estop     = cfg_wdata_i;
        dfr_pkg::CFG_ID_PING:      cfg_d.id_ping      = cfg_wdata_i;
        dfr_pkg::CFG_MAX_LEN:      cfg_d.max_len      = cfg_wdata_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first  <= dfr_pkg::RstStartFirst;
      cfg_q.start_second <= dfr_pkg::RstStartSecond;
      cfg_q.id_drive     <= dfr_pkg::RstIdDrive;
      cfg_q.id_enable    <= dfr_pkg::RstIdEnable;
      cfg_q.id_estop     <= dfr_pkg::RstIdEstop;
      cfg_q.id_ping      <= dfr_pkg::RstIdPing;
      cfg_q.max_len      <= dfr_pkg::RstMaxLen;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: hw/rtl/dfr_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_in_reg: input byte register
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module dfr_in_reg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [dfr_pkg::ByteW-1:0] rx_byte_i,
  input  wire logic                      consume_i,
  output      logic                      valid_o,
  output      logic [dfr_pkg::ByteW-1:0] byte_o
);

  logic                      valid_d, valid_q;
  logic [dfr_pkg::ByteW-1:0] byte_q;
  logic                      load;

  // free when empty or when the held byte leaves this cycle
  assign in_stall_o = valid_q && !consume_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !consume_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule
`default_nettype wire

// File: hw/rtl/dfr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_parser: frame parser with running CRC
// One byte per step: start byte hunt, header, payload pass-through, CRC
// check and dispatch verdict.
// ----------------------------------------------------------------------------
module dfr_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  dfr_pkg::cfg_t                  cfg_i,
  input  wire logic                      step_i,
  input  wire logic [dfr_pkg::ByteW-1:0] byte_i,
  output      logic                      has_result_o,
  output dfr_pkg::result_t               result_o
);

  dfr_pkg::phase_e           phase_d, phase_q;
  logic [dfr_pkg::ByteW-1:0] msg_id_d, msg_id_q;
  logic [dfr_pkg::ByteW-1:0] length_d, length_q;
  logic [dfr_pkg::ByteW-1:0] count_d, count_q;
  logic [dfr_pkg::CrcW-1:0]  crc_d, crc_q;
  logic [dfr_pkg::ByteW-1:0] crc_low_d, crc_low_q;

  logic [dfr_pkg::CrcW-1:0]  crc_upd;
  logic [dfr_pkg::ByteW-1:0] count_inc;
  logic                      crc_match;

  assign crc_upd   = dfr_pkg::crc_byte(crc_q, byte_i);
  assign count_inc = count_q + 8'd1;
  assign crc_match = ({byte_i, crc_low_q} == crc_q);

  // next state
  always_comb begin
    phase_d   = phase_q;
    msg_id_d  = msg_id_q;
    length_d  = length_q;
    count_d   = count_q;
    crc_d     = crc_q;
    crc_low_d = crc_low_q;
    if (step_i) begin
      unique case (phase_q)
        dfr_pkg::PH_SOF0: begin
          if (byte_i == cfg_i.start_first) phase_d = dfr_pkg::PH_SOF1;
        end
        dfr_pkg::PH_SOF1: begin
          phase_d = (byte_i == cfg_i.start_second) ? dfr_pkg::PH_MSG : dfr_pkg::PH_SOF0;
        end
        dfr_pkg::PH_MSG: begin
          msg_id_d = byte_i;
          crc_d    = dfr_pkg::crc_byte(dfr_pkg::CrcInit, byte_i);
          phase_d  = dfr_pkg::PH_LEN;
        end
        dfr_pkg::PH_LEN: begin
          length_d = byte_i;
          if (byte_i > cfg_i.max_len) begin
            phase_d = dfr_pkg::PH_SOF0;
          end else begin
            crc_d   = crc_upd;
            count_d = '0;
            phase_d = (byte_i == dfr_pkg::LenPing) ? dfr_pkg::PH_CRC_L
                                                   : dfr_pkg::PH_PAYLOAD;
          end
        end
        dfr_pkg::PH_PAYLOAD: begin
          crc_d   = crc_upd;
          count_d = count_inc;
          if (count_inc >= length_q) phase_d = dfr_pkg::PH_CRC_L;
        end
        dfr_pkg::PH_CRC_L: begin
          crc_low_d = byte_i;
          phase_d   = dfr_pkg::PH_CRC_H;
        end
        dfr_pkg::PH_CRC_H: begin
          phase_d = dfr_pkg::PH_SOF0;
        end
        default: begin
          phase_d = dfr_pkg::PH_SOF0;
        end
      endcase
    end
  end

  // result for this byte
  always_comb begin
    has_result_o          = 1'b0;
    result_o.kind         = dfr_pkg::KIND_PAYLOAD;
    result_o.payload_byte = '0;
    result_o.msg_id       = msg_id_q;
    result_o.length       = length_q;
    result_o.crc_good     = 1'b0;
    result_o.accepted     = 1'b0;
    result_o.ack_wanted   = 1'b0;
    result_o.ack_code     = dfr_pkg::ACK_OK;
    if (phase_q == dfr_pkg::PH_PAYLOAD) begin
      has_result_o          = 1'b1;
      result_o.payload_byte = byte_i;
    end else if (phase_q == dfr_pkg::PH_CRC_H) begin
      has_result_o      = 1'b1;
      result_o.kind     = dfr_pkg::KIND_VERDICT;
      result_o.crc_good = crc_match;
      priority if (!crc_match) begin
        result_o.ack_wanted = 1'b1;
        result_o.ack_code   = dfr_pkg::ACK_CRC_ERR;
      end else if (msg_id_q == cfg_i.id_drive) begin
        if (length_q == dfr_pkg::LenMotorDrive) begin
          result_o.accepted = 1'b1;
        end else begin
          result_o.ack_wanted = 1'b1;
          result_o.ack_code   = dfr_pkg::ACK_LEN_ERR;
        end
      end else if (msg_id_q == cfg_i.id_enable || msg_id_q == cfg_i.id_estop) begin
        result_o.ack_wanted = 1'b1;
        if (length_q == dfr_pkg::LenShortCmd) begin
          result_o.accepted = 1'b1;
        end else begin
          result_o.ack_code = dfr_pkg::ACK_LEN_ERR;
        end
      end else if (msg_id_q == cfg_i.id_ping) begin
        // ping with a wrong length is rejected without an ack
        if (length_q == dfr_pkg::LenPing) begin
          result_o.accepted   = 1'b1;
          result_o.ack_wanted = 1'b1;
        end
      end else begin
        result_o.ack_wanted = 1'b1;
        result_o.ack_code   = dfr_pkg::ACK_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= dfr_pkg::PH_SOF0;
      msg_id_q  <= '0;
      length_q  <= '0;
      count_q   <= '0;
      crc_q     <= dfr_pkg::CrcInit;
      crc_low_q <= '0;
    end else begin
      phase_q   <= phase_d;
      msg_id_q  <= msg_id_d;
      length_q  <= length_d;
      count_q   <= count_d;
      crc_q     <= crc_d;
      crc_low_q <= crc_low_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dfr_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_out_reg: result register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module dfr_out_reg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic        has_result_i,
  input  dfr_pkg::result_t result_i,
  input  wire logic        out_stall_i,
  output      logic        out_valid_o,
  output      logic        free_o,
  output dfr_pkg::result_t result_o
);

  logic             valid_d, valid_q;
  dfr_pkg::result_t result_q;

  assign free_o = !valid_q || !out_stall_i;

  // load_i is only raised while free_o holds
  always_comb begin
    if (load_i) begin
      valid_d = has_result_i;
    end else begin
      valid_d = valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && has_result_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule
`default_nettype wire

// File: hw/rtl/framed_packet_deframer_crc16_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framed_packet_deframer_crc16_top: byte-stream deframer with CRC16 check
// Finds start bytes, checks CRC16-CCITT-FALSE over id, length and payload,
// passes payload bytes out and ends each frame with a dispatch verdict.
// ----------------------------------------------------------------------------
//   channel  handshake                payload
//   in       in_valid_i/in_stall_o    rx_byte_i
//   out      out_valid_o/out_stall_i  item_kind_o .. ack_code_o
//   cfg      cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// One byte per cycle sustained while the output is not stalled. A byte is held in
// the input register, the parser steps on it and any result lands in the output
// register, so each result reaches the outputs through the input and output
// registers and is held there until taken. Reset clears all control state and
// loads the register defaults. An output stall holds the result and backs up
// through the input register within the same cycle.
// ----------------------------------------------------------------------------
module framed_packet_deframer_crc16_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [2:0]                cfg_index_i,
  input  wire logic [dfr_pkg::ByteW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [dfr_pkg::ByteW-1:0] rx_byte_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic                      item_kind_o,
  output      logic [dfr_pkg::ByteW-1:0] payload_byte_o,
  output      logic [dfr_pkg::ByteW-1:0] frame_msg_id_o,
  output      logic [dfr_pkg::ByteW-1:0] frame_length_o,
  output      logic                      crc_good_o,
  output      logic                      frame_accepted_o,
  output      logic                      ack_wanted_o,
  output      logic [1:0]                ack_code_o
);

  dfr_pkg::cfg_t             cfg;
  logic                      byte_valid;
  logic [dfr_pkg::ByteW-1:0] byte_q;
  logic                      out_free;
  logic                      step;
  logic                      has_result;
  dfr_pkg::result_t          result;
  dfr_pkg::result_t          result_q;

  assign step = byte_valid && out_free;

  dfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dfr_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .consume_i  (step),
    .valid_o    (byte_valid),
    .byte_o     (byte_q)
  );

  dfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (step),
    .byte_i       (byte_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  dfr_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .has_result_i (has_result),
    .result_i     (result),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .free_o       (out_free),
    .result_o     (result_q)
  );

  assign item_kind_o      = result_q.kind;
  assign payload_byte_o   = result_q.payload_byte;
  assign frame_msg_id_o   = result_q.msg_id;
  assign frame_length_o   = result_q.length;
  assign crc_good_o       = result_q.crc_good;
  assign frame_accepted_o = result_q.accepted;
  assign ack_wanted_o     = result_q.ack_wanted;
  assign ack_code_o       = result_q.ack_code;

endmodule
`default_nettype wire

// File: bench/frame_verdict_checker.sv
// ----------------------------------------------------------------------------
// frame_verdict_checker: scoreboard for the framed packet deframer
// Mirrors the parser state and register file from the observed requests,
// queues the expected payload and verdict results, and compares each
// accepted result field by field against the oldest expected one.
// ----------------------------------------------------------------------------
package frame_math_pkg;

  // CRC16-CCITT-FALSE over one byte, processed one bit at a time
  function automatic logic [15:0] crc16_next(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c  = c << 1;
      if (fb) begin
        c = c ^ dfr_pkg::CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

module frame_verdict_checker
  import dfr_pkg::*;
  import frame_math_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       item_kind_i,
  input  logic [7:0] payload_byte_i,
  input  logic [7:0] frame_msg_id_i,
  input  logic [7:0] frame_length_i,
  input  logic       crc_good_i,
  input  logic       frame_accepted_i,
  input  logic       ack_wanted_i,
  input  logic [1:0] ack_code_i,
  output int         fail_count_o,
  output int         pending_o
);

  cfg_t        regs;
  phase_e      phase;
  logic [7:0]  cur_id;
  logic [7:0]  cur_len;
  logic [7:0]  rx_count;
  logic [7:0]  crc_lo;
  logic [15:0] crc_acc;
  result_t     expected_results[$];
  int          fails = 0;

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // advance the parser by one byte, queue whatever result it produces
  task automatic parse_rx_byte(input logic [7:0] b);
    result_t     r;
    logic [15:0] rx_crc;
    r = '0;
    case (phase)
      PH_SOF0: begin
        if (b == regs.start_first) phase = PH_SOF1;
      end
      PH_SOF1: begin
        if (b == regs.start_second) phase = PH_MSG;
        else phase = PH_SOF0;
      end
      PH_MSG: begin
        cur_id  = b;
        crc_acc = crc16_next(CrcInit, b);
        phase   = PH_LEN;
      end
      PH_LEN: begin
        cur_len = b;
        if (b > regs.max_len) begin
          // oversize frame is dropped without a verdict
          phase = PH_SOF0;
        end else begin
          crc_acc  = crc16_next(crc_acc, b);
          rx_count = '0;
          if (b == 8'd0) phase = PH_CRC_L;
          else phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_acc  = crc16_next(crc_acc, b);
        rx_count = rx_count + 8'd1;
        if (rx_count >= cur_len) phase = PH_CRC_L;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.msg_id       = cur_id;
        r.length       = cur_len;
        r.ack_code     = ACK_OK;
        expected_results.push_back(r);
      end
      PH_CRC_L: begin
        crc_lo = b;
        phase  = PH_CRC_H;
      end
      PH_CRC_H: begin
        phase    = PH_SOF0;
        rx_crc   = {b, crc_lo};
        r.kind   = KIND_VERDICT;
        r.msg_id = cur_id;
        r.length = cur_len;
        r.crc_good = 1'b1;
        r.ack_code = ACK_OK;
        // id match priority: drive, enable/stop, ping
        if (rx_crc != crc_acc) begin
          r.crc_good   = 1'b0;
          r.ack_wanted = 1'b1;
          r.ack_code   = ACK_CRC_ERR;
        end else if (cur_id == regs.id_drive) begin
          r.accepted   = (cur_len == LenMotorDrive);
          r.ack_wanted = !r.accepted;
          if (!r.accepted) r.ack_code = ACK_LEN_ERR;
        end else if (cur_id == regs.id_enable || cur_id == regs.id_estop) begin
          r.accepted   = (cur_len == LenShortCmd);
          r.ack_wanted = 1'b1;
          if (!r.accepted) r.ack_code = ACK_LEN_ERR;
        end else if (cur_id == regs.id_ping) begin
          // a ping of the wrong length gets no ack at all
          r.accepted   = (cur_len == LenPing);
          r.ack_wanted = r.accepted;
        end else begin
          r.ack_wanted = 1'b1;
          r.ack_code   = ACK_UNKNOWN;
        end
        expected_results.push_back(r);
      end
      default: phase = PH_SOF0;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      regs.start_first  = RstStartFirst;
      regs.start_second = RstStartSecond;
      regs.id_drive     = RstIdDrive;
      regs.id_enable    = RstIdEnable;
      regs.id_estop     = RstIdEstop;
      regs.id_ping      = RstIdPing;
      regs.max_len      = RstMaxLen;
      phase    = PH_SOF0;
      cur_id   = '0;
      cur_len  = '0;
      rx_count = '0;
      crc_lo   = '0;
      crc_acc  = CrcInit;
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, kind %0d byte 0x%0h id 0x%0h", $time,
                   item_kind_i, payload_byte_i, frame_msg_id_i);
        end else begin
          want = expected_results.pop_front();
          check_field("item_kind", want.kind, item_kind_i);
          check_field("payload_byte", want.payload_byte, payload_byte_i);
          check_field("frame_msg_id", want.msg_id, frame_msg_id_i);
          check_field("frame_length", want.length, frame_length_i);
          check_field("crc_good", want.crc_good, crc_good_i);
          check_field("frame_accepted", want.accepted, frame_accepted_i);
          check_field("ack_wanted", want.ack_wanted, ack_wanted_i);
          check_field("ack_code", want.ack_code, ack_code_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_START_FIRST:  regs.start_first  = cfg_wdata_i;
          CFG_START_SECOND: regs.start_second = cfg_wdata_i;
          CFG_ID_DRIVE:     regs.id_drive     = cfg_wdata_i;
          CFG_ID_ENABLE:    regs.id_enable    = cfg_wdata_i;
          CFG_ID_ESTOP:     regs.id_estop     = cfg_wdata_i;
          CFG_ID_PING:      regs.id_ping      = cfg_wdata_i;
          CFG_MAX_LEN:      regs.max_len      = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        parse_rx_byte(rx_byte_i);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_results.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: top-level bench for the framed packet deframer
// Drives a byte stream of well-formed, corrupted, oversize and truncated
// frames plus line noise under several register settings, with random gaps
// and output stalls; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb;
  import dfr_pkg::*;
  import frame_math_pkg::*;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_we      = 1'b0;
  logic [2:0] cfg_index   = '0;
  logic [7:0] cfg_wdata   = '0;
  logic       in_valid    = 1'b0;
  logic [7:0] rx_byte     = '0;
  logic       out_stall   = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       item_kind;
  logic [7:0] payload_byte;
  logic [7:0] frame_msg_id;
  logic [7:0] frame_length;
  logic       crc_good;
  logic       frame_accepted;
  logic       ack_wanted;
  logic [1:0] ack_code;
  int         fail_count;
  int         pending;

  bit         hold_req   = 1'b0;
  bit         no_gaps    = 1'b0;
  int         sent_bytes = 0;
  cfg_t       shadow_cfg;
  logic [7:0] frame_q[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  framed_packet_deframer_crc16_top u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .item_kind_o      (item_kind),
    .payload_byte_o   (payload_byte),
    .frame_msg_id_o   (frame_msg_id),
    .frame_length_o   (frame_length),
    .crc_good_o       (crc_good),
    .frame_accepted_o (frame_accepted),
    .ack_wanted_o     (ack_wanted),
    .ack_code_o       (ack_code)
  );

  frame_verdict_checker u_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .item_kind_i      (item_kind),
    .payload_byte_i   (payload_byte),
    .frame_msg_id_i   (frame_msg_id),
    .frame_length_i   (frame_length),
    .crc_good_i       (crc_good),
    .frame_accepted_i (frame_accepted),
    .ack_wanted_i     (ack_wanted),
    .ack_code_i       (ack_code),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(0, 12);
    if (r < 98) return $urandom_range(13, 40);
    return $urandom_range(200, 255);
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.start_first  = $urandom;
    c.start_second = $urandom;
    c.id_drive     = $urandom;
    c.id_enable    = $urandom;
    c.id_estop     = $urandom;
    c.id_ping      = $urandom;
    c.max_len      = $urandom_range(10, 255);
    return c;
  endfunction

  // valid stays high across back-to-back requests; data changes only on accept
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic flush_frame();
    foreach (frame_q[i]) push_byte(frame_q[i]);
    frame_q.delete();
  endtask

  task automatic build_frame(input logic [7:0] id, input logic [7:0] len,
                             input bit crc_ok);
    logic [15:0] crc;
    logic [7:0]  b;
    frame_q.push_back(shadow_cfg.start_first);
    frame_q.push_back(shadow_cfg.start_second);
    frame_q.push_back(id);
    frame_q.push_back(len);
    crc = crc16_next(CrcInit, id);
    crc = crc16_next(crc, len);
    for (int i = 0; i < len; i++) begin
      b = $urandom;
      frame_q.push_back(b);
      crc = crc16_next(crc, b);
    end
    if (!crc_ok) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endtask

  task automatic random_frame();
    int         r;
    bit         known;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] need;
    logic [7:0] b;
    r       = $urandom_range(0, 99);
    no_gaps = ($urandom_range(0, 9) == 0);
    if (r < 75) begin
      known = 1'b1;
      need  = '0;
      case ($urandom_range(0, 9))
        0, 1: begin id = shadow_cfg.id_drive;  need = LenMotorDrive; end
        2:    begin id = shadow_cfg.id_enable; need = LenShortCmd;   end
        3:    begin id = shadow_cfg.id_estop;  need = LenShortCmd;   end
        4, 5: begin id = shadow_cfg.id_ping;   need = LenPing;       end
        default: begin id = $urandom; known = 1'b0; end
      endcase
      if (known && $urandom_range(0, 9) < 6) len = need;
      else len = pick_len();
      if (len > shadow_cfg.max_len) len = $urandom_range(0, shadow_cfg.max_len);
      build_frame(id, len, $urandom_range(0, 4) != 0);
    end else if (r < 85 && shadow_cfg.max_len != 8'hFF) begin
      // announced length over the limit: header only, frame is dropped
      frame_q.push_back(shadow_cfg.start_first);
      frame_q.push_back(shadow_cfg.start_second);
      frame_q.push_back($urandom);
      frame_q.push_back($urandom_range(shadow_cfg.max_len + 1, 255));
    end else if (r < 93) begin
      if ($urandom_range(0, 1) == 0) begin
        b = $urandom;
        if (b == shadow_cfg.start_second) b = ~b;
        frame_q.push_back(shadow_cfg.start_first);
        frame_q.push_back(b);
      end else begin
        // truncated frame; following bytes get parsed as its tail
        build_frame($urandom, $urandom_range(0, shadow_cfg.max_len < 8 ?
                    shadow_cfg.max_len : 8), 1'b1);
        repeat ($urandom_range(1, 3)) void'(frame_q.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 6)) frame_q.push_back($urandom);
    end
    flush_frame();
  endtask

  task automatic run_phase(input int n);
    int stop;
    stop = sent_bytes + n;
    while (sent_bytes < stop) random_frame();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    cfg_idx_e   order [7];
    logic [7:0] vals  [7];
    order = '{CFG_START_FIRST, CFG_START_SECOND, CFG_ID_DRIVE, CFG_ID_ENABLE,
              CFG_ID_ESTOP, CFG_ID_PING, CFG_MAX_LEN};
    vals  = '{c.start_first, c.start_second, c.id_drive, c.id_enable,
              c.id_estop, c.id_ping, c.max_len};
    cfg_we <= 1'b1;
    for (int i = 0; i < 7; i++) begin
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    shadow_cfg = c;
  endtask

  // output side: random stalls, quiet stretches, one long hold-off on request
  initial begin
    int r;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
          out_stall <= 1'b1;
          if (r < 90) repeat ($urandom_range(1, 3)) @(posedge clk);
          else repeat ($urandom_range(10, 30)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int   k;
    cfg_t c;
    shadow_cfg = '{RstStartFirst, RstStartSecond, RstIdDrive, RstIdEnable,
                   RstIdEstop, RstIdPing, RstMaxLen};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // second start byte mismatch; the mismatching byte is not a new first byte
    frame_q = '{8'h00, RstStartFirst, RstStartFirst, RstStartSecond};
    flush_frame();
    build_frame(RstIdPing, LenPing, 1'b1);
    build_frame(RstIdDrive, 8'd0, 1'b1);
    build_frame(8'hFF, 8'd1, 1'b1);
    build_frame(RstIdEnable, LenShortCmd, 1'b0);
    flush_frame();
    wait_idle();

    // long receiver hold-off so the pipeline fills and backs up the input
    hold_req = 1'b1;
    while (hold_req) @(posedge clk);
    no_gaps = 1'b1;
    build_frame(shadow_cfg.id_drive, 8'd40, 1'b1);
    flush_frame();
    run_phase(150);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: c = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h00};
        1: c = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFE, 8'h01, 8'hFF};
        2: c = '{8'h7E, 8'h7E, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'd12};
        default: c = random_cfg();
      endcase
      wait_idle();
      apply_config(c);
      run_phase(185);
    end

    in_valid <= 1'b0;
    for (k = 0; k < 20000 && pending != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
